// ===== hdl/tqcs_pkg.sv =====
// Package: shared types, constants and register indexes for the quad clip setup block
`default_nettype none
package tqcs_pkg;
  localparam int DivW = 48;   // dividend magnitude bits
  localparam int DenW = 30;   // divisor bits (rect size times texture size)
  localparam int QW   = 20;   // quotient bits kept before saturation

  typedef enum logic [2:0] {
    REG_LIMIT_X = 3'd0, REG_LIMIT_Y = 3'd1, REG_LIMIT_W = 3'd2, REG_LIMIT_H = 3'd3,
    REG_SCREEN_W = 3'd4, REG_SCREEN_H = 3'd5, REG_TEX_W = 3'd6, REG_TEX_H = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_STORE, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // capture input item and evaluate axes
    logic zero;      // clear held quad
    logic commit;    // store edges, position, numerators and divisors
    logic div_start; // start division of selected coordinate
    logic div_store; // store quotient into held coordinate
    logic [1:0] sel; // coordinate under division
  } cmd_t;

  typedef struct packed {
    logic skip_zero;  // empty sprite or origin outside sprite
    logic skip_hold;  // unchanged position and no change of limits
    logic div_done;
  } status_t;
endpackage
`default_nettype wire

// ===== hdl/tqcs_ctrl.sv =====
// Controller: sequences one transaction through setup and, when recomputed, four divisions
`default_nettype none
module tqcs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               out_stall,
  input  wire tqcs_pkg::status_t  status,
  output tqcs_pkg::cmd_t          cmd,
  output logic                    in_stall,
  output logic                    out_valid,
  output logic                    redrawn_set,
  output logic                    redrawn_val
);
  tqcs_pkg::state_t state, state_next;
  logic [1:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tqcs_pkg::ST_IDLE;
      sel <= 2'd0;
    end else begin
      state <= state_next;
      sel <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next = sel;
    unique case (state)
      tqcs_pkg::ST_IDLE: if (in_valid) state_next = tqcs_pkg::ST_SETUP;
      tqcs_pkg::ST_SETUP: begin
        sel_next = 2'd0;
        if (status.skip_zero || status.skip_hold) state_next = tqcs_pkg::ST_OUT;
        else state_next = tqcs_pkg::ST_DIV_LOAD;
      end
      tqcs_pkg::ST_DIV_LOAD: state_next = tqcs_pkg::ST_DIV_RUN;
      tqcs_pkg::ST_DIV_RUN: if (status.div_done) state_next = tqcs_pkg::ST_DIV_STORE;
      tqcs_pkg::ST_DIV_STORE: begin
        sel_next = sel + 2'd1;
        state_next = (sel == 2'd3) ? tqcs_pkg::ST_OUT : tqcs_pkg::ST_DIV_LOAD;
      end
      tqcs_pkg::ST_OUT: if (!out_stall) state_next = tqcs_pkg::ST_IDLE;
      default: state_next = tqcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.sel = sel;
    in_stall = 1'b1;
    out_valid = 1'b0;
    redrawn_set = 1'b0;
    redrawn_val = 1'b1;
    unique case (state)
      tqcs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      tqcs_pkg::ST_SETUP: begin
        redrawn_set = 1'b1;
        redrawn_val = !status.skip_hold || status.skip_zero;
        cmd.zero = status.skip_zero;
        cmd.commit = !status.skip_zero && !status.skip_hold;
      end
      tqcs_pkg::ST_DIV_LOAD: cmd.div_start = 1'b1;
      tqcs_pkg::ST_DIV_RUN: ;
      tqcs_pkg::ST_DIV_STORE: cmd.div_store = 1'b1;
      tqcs_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == tqcs_pkg::ST_OUT && out_stall) |=> state == tqcs_pkg::ST_OUT)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    (state == tqcs_pkg::ST_DIV_STORE && sel == 2'd3) |=> state == tqcs_pkg::ST_OUT)
    else $error("division sequence overran");
  assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input taken while result pending");
endmodule
`default_nettype wire

// ===== hdl/tqcs_div.sv =====
// Restoring divider, one quotient bit per cycle, round to nearest
`default_nettype none
module tqcs_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [tqcs_pkg::DivW-1:0]  num,  // magnitude
  input  wire logic [tqcs_pkg::DenW-1:0]  den,
  output logic [tqcs_pkg::QW-1:0]         quo,
  output logic                            done
);
  localparam int NW = tqcs_pkg::DivW + 2;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] dvd;                 // 2m + d, consumed from the top
  logic [tqcs_pkg::DenW+1:0] dsr;     // 2d
  logic [tqcs_pkg::DenW+1:0] rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic busy;
  logic [tqcs_pkg::DenW+2:0] trial;

  assign trial = {rem, dvd[NW-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {1'b0, num, 1'b0} + NW'(den);
      dsr <= {1'b0, den, 1'b0};
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      dvd <= {dvd[NW-2:0], 1'b0};
      if (!trial[tqcs_pkg::DenW+2]) begin
        rem <= trial[tqcs_pkg::DenW+1:0];
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[tqcs_pkg::DenW:0], dvd[NW-1]};
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end

  // saturate the quotient to the kept width
  assign quo = (|q[NW-1:tqcs_pkg::QW]) ? {tqcs_pkg::QW{1'b1}} : q[tqcs_pkg::QW-1:0];
endmodule
`default_nettype wire

// ===== hdl/tqcs_dp.sv =====
// Datapath: registers, axis setup, edges, held quad and coordinate division
`default_nettype none
module tqcs_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx_low,
  input  wire logic               cfg_idx_ok,
  input  wire logic [15:0]        cfg_data,
  input  wire logic signed [15:0] rect_x,
  input  wire logic signed [15:0] rect_y,
  input  wire logic [14:0]        rect_w,
  input  wire logic [14:0]        rect_h,
  input  wire logic [14:0]        clip_x,
  input  wire logic [14:0]        clip_y,
  input  wire logic [14:0]        clip_w,
  input  wire logic [14:0]        clip_h,
  input  wire tqcs_pkg::cmd_t     cmd,
  output tqcs_pkg::status_t       status,
  output logic signed [17:0]      edges [4],
  output logic signed [15:0]      tcs [4]
);
  logic signed [15:0] lx, ly, lw, lh;
  logic [14:0] sw, sh, tw, th;
  logic lim_chg;
  logic [15:0] last_x, last_y;
  logic signed [15:0] rx, ry;
  logic [14:0] rw, rh, cx, cy, cw, ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      lx <= '0; ly <= '0; lw <= '0; lh <= '0;
      sw <= 15'd640; sh <= 15'd480; tw <= 15'd256; th <= 15'd256;
    end else if (cfg_we && cfg_idx_ok) begin
      unique case (tqcs_pkg::reg_idx_t'(cfg_idx_low))
        tqcs_pkg::REG_LIMIT_X:  lx <= cfg_data;
        tqcs_pkg::REG_LIMIT_Y:  ly <= cfg_data;
        tqcs_pkg::REG_LIMIT_W:  lw <= cfg_data;
        tqcs_pkg::REG_LIMIT_H:  lh <= cfg_data;
        tqcs_pkg::REG_SCREEN_W: sw <= cfg_data[14:0];
        tqcs_pkg::REG_SCREEN_H: sh <= cfg_data[14:0];
        tqcs_pkg::REG_TEX_W:    tw <= cfg_data[14:0];
        tqcs_pkg::REG_TEX_H:    th <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic cfg_diff;
  always_comb begin
    cfg_diff = 1'b0;
    unique case (tqcs_pkg::reg_idx_t'(cfg_idx_low))
      tqcs_pkg::REG_LIMIT_X: cfg_diff = cfg_data != lx;
      tqcs_pkg::REG_LIMIT_Y: cfg_diff = cfg_data != ly;
      tqcs_pkg::REG_LIMIT_W: cfg_diff = cfg_data != lw;
      tqcs_pkg::REG_LIMIT_H: cfg_diff = cfg_data != lh;
      default: cfg_diff = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx <= rect_x; ry <= rect_y; rw <= rect_w; rh <= rect_h;
      cx <= clip_x; cy <= clip_y; cw <= clip_w; ch <= clip_h;
    end
  end

  // axis evaluation, exact integer, numerators kept over sprite size
  logic signed [17:0] ext_x, ext_y;
  logic signed [33:0] t0x, t1x, t0y, t1y;

  function automatic void axis_f(input logic signed [15:0] lo, input logic signed [15:0] lsz,
      input logic [14:0] sz, input logic [14:0] c, input logic [14:0] cs,
      output logic signed [17:0] ext, output logic signed [33:0] t0,
      output logic signed [33:0] t1);
    logic signed [17:0] alo, calc, cons, real_v, szs;
    logic signed [33:0] toff, tlen, csa;
    logic over;
    alo = lo < 0 ? -18'(lo) : 18'(lo);
    calc = lsz < 0 ? 18'(lsz) - alo : 18'(lsz);
    cons = lo < 0 ? 18'sd0 : 18'(lo);
    szs = $signed({3'b0, sz});
    over = (18'(lo) + calc) > szs;
    real_v = over ? szs - cons : calc;
    if (real_v < 0) real_v = (real_v + 18'(lo) > 0) ? real_v + 18'(lo) : 18'sd0;
    ext = real_v;
    csa = $signed(34'({1'b0, cs}) * 34'(alo));
    t0 = $signed(34'({1'b0, c}) * 34'({1'b0, sz})) + (lo < 0 ? csa : 34'sd0);
    toff = (over || lo < 0) ? csa : 34'sd0;
    tlen = $signed(34'({1'b0, cs}) * 34'({1'b0, sz})) - toff;
    if (18'(lsz) < szs) tlen = tlen - $signed(34'({1'b0, cs}) * 34'(szs - 18'(lsz)));
    t1 = t0 + tlen;
  endfunction

  always_comb begin
    axis_f(lx, lw, rw, cx, cw, ext_x, t0x, t1x);
    axis_f(ly, lh, rh, cy, ch, ext_y, t0y, t1y);
  end

  logic signed [16:0] realx, realy;
  assign realx = lx < 0 ? 17'(rx) : 17'(rx) + 17'(lx);
  assign realy = ly < 0 ? 17'(ry) : 17'(ry) + 17'(ly);

  assign status.skip_zero = (rw == '0) || (rh == '0) ||
                            (lx >= $signed({1'b0, rw})) || (ly >= $signed({1'b0, rh}));
  assign status.skip_hold = (realx[15:0] == last_x) && (realy[15:0] == last_y) && !lim_chg;

  function automatic logic signed [17:0] sat18(input logic signed [20:0] v);
    if (v > 21'sd131071) return 18'sd131071;
    if (v < -21'sd131072) return -18'sd131072;
    return v[17:0];
  endfunction

  logic signed [20:0] e0, e2;
  assign e0 = 21'(realx) * 21'sd2 - 21'($signed({1'b0, sw}));
  assign e2 = 21'($signed({1'b0, sh})) - 21'(realy) * 21'sd2;

  // held numerators for the divisions
  logic signed [33:0] nums [4];
  logic [29:0] den_x, den_y;
  logic [14:0] twe, the;
  assign twe = (tw == '0) ? 15'd1 : tw;
  assign the = (th == '0) ? 15'd1 : th;

  logic signed [33:0] nsel;
  logic [33:0] nabs;
  logic neg_r;
  logic [19:0] quo;
  logic done;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_chg <= 1'b0;
      last_x <= 16'hFFFF;
      last_y <= 16'hFFFF;
      for (int i = 0; i < 4; i++) begin
        edges[i] <= '0;
        tcs[i] <= '0;
      end
    end else begin
      if (cfg_we && cfg_idx_ok && cfg_diff) lim_chg <= 1'b1;
      if (cmd.zero) begin
        for (int i = 0; i < 4; i++) begin
          edges[i] <= '0;
          tcs[i] <= '0;
        end
      end
      if (cmd.commit) begin
        lim_chg <= 1'b0;
        last_x <= realx[15:0];
        last_y <= realy[15:0];
        edges[0] <= sat18(e0);
        edges[1] <= sat18(e0 + 21'(ext_x) * 21'sd2);
        edges[2] <= sat18(e2);
        edges[3] <= sat18(e2 - 21'(ext_y) * 21'sd2);
        nums[0] <= t0x; nums[1] <= t1x; nums[2] <= t0y; nums[3] <= t1y;
        den_x <= rw * twe;
        den_y <= rh * the;
      end
      if (cmd.div_store) begin
        if (neg_r) tcs[cmd.sel] <= (quo > 20'd32768) ? -16'sd32768 : -16'(quo);
        else       tcs[cmd.sel] <= (quo > 20'd32767) ? 16'sd32767 : 16'(quo);
      end
    end
  end

  assign nsel = nums[cmd.sel];
  assign nabs = nsel < 0 ? 34'(-nsel) : 34'(nsel);
  always_ff @(posedge clk) if (cmd.div_start) neg_r <= nsel < 0;

  tqcs_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num({nabs, 14'd0}),
    .den(cmd.sel[1] ? den_y : den_x),
    .quo(quo), .done(done)
  );
  assign status.div_done = done;
endmodule
`default_nettype wire

// ===== hdl/textured_quad_clip_setup_top.sv =====
// Top level: textured quad clip setup, controller plus datapath
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | rect_x..clip_h
//  out     | output    | out_valid/out_stall| edge_left..v_bottom, redrawn
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One transaction at a time. A held or zero result skips the divisions; a recomputed
// quad runs four divisions in turn on the shared bit-serial divider.
// rst is synchronous; it restores the register defaults and clears held state.
// While a result waits under out_stall, hold it and keep in_stall high.
`default_nettype none
module textured_quad_clip_setup_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] rect_x,
  input  wire logic signed [15:0] rect_y,
  input  wire logic [14:0]        rect_w,
  input  wire logic [14:0]        rect_h,
  input  wire logic [14:0]        clip_x,
  input  wire logic [14:0]        clip_y,
  input  wire logic [14:0]        clip_w,
  input  wire logic [14:0]        clip_h,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [17:0]      edge_left,
  output logic signed [17:0]      edge_right,
  output logic signed [17:0]      edge_top,
  output logic signed [17:0]      edge_bottom,
  output logic signed [15:0]      u_left,
  output logic signed [15:0]      u_right,
  output logic signed [15:0]      v_top,
  output logic signed [15:0]      v_bottom,
  output logic                    redrawn,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  tqcs_pkg::cmd_t cmd;
  tqcs_pkg::status_t status;
  logic rd_set, rd_val;
  logic signed [17:0] edges [4];
  logic signed [15:0] tcs [4];

  tqcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd), .in_stall(in_stall), .out_valid(out_valid),
    .redrawn_set(rd_set), .redrawn_val(rd_val)
  );

  tqcs_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx_low(cfg_index[2:0]),
    .cfg_idx_ok(!cfg_index[3]), .cfg_data(cfg_data),
    .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
    .clip_x(clip_x), .clip_y(clip_y), .clip_w(clip_w), .clip_h(clip_h),
    .cmd(cmd), .status(status), .edges(edges), .tcs(tcs)
  );

  // capture the redrawn flag when the transaction is classified
  always_ff @(posedge clk) begin
    if (rd_set) redrawn <= rd_val;
  end

  assign edge_left = edges[0];
  assign edge_right = edges[1];
  assign edge_top = edges[2];
  assign edge_bottom = edges[3];
  assign u_left = tcs[0];
  assign u_right = tcs[1];
  assign v_top = tcs[2];
  assign v_bottom = tcs[3];
endmodule
`default_nettype wire

// ===== test/quad_clip_checker.sv =====
// Checker: predicts each clipped quad from the input transactions and compares the results
`timescale 1ns / 100ps
`default_nettype none
module quad_clip_checker
  import tqcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [15:0] rect_x,
  input  wire logic signed [15:0] rect_y,
  input  wire logic [14:0]        rect_w,
  input  wire logic [14:0]        rect_h,
  input  wire logic [14:0]        clip_x,
  input  wire logic [14:0]        clip_y,
  input  wire logic [14:0]        clip_w,
  input  wire logic [14:0]        clip_h,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [17:0] edge_left,
  input  wire logic signed [17:0] edge_right,
  input  wire logic signed [17:0] edge_top,
  input  wire logic signed [17:0] edge_bottom,
  input  wire logic signed [15:0] u_left,
  input  wire logic signed [15:0] u_right,
  input  wire logic signed [15:0] v_top,
  input  wire logic signed [15:0] v_bottom,
  input  wire logic               redrawn,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      mismatches,
  output int                      awaiting
);
  typedef struct packed {
    logic signed [17:0] el, er, et, eb;
    logic signed [15:0] ul, ur, vt, vb;
    logic               rd;
  } quad_t;

  logic [15:0] lim_x, lim_y, lim_w, lim_h;
  logic [14:0] scr_w, scr_h, tex_w, tex_h;
  logic [15:0] pos_x, pos_y;
  bit          lim_dirty;
  quad_t       held_quad;
  quad_t       quad_expected[$];

  assign awaiting = quad_expected.size();

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [15:0] to_q14(longint num, longint den);
    longint n, q;
    n = num * 16384;
    q = (2 * mag(n) + den) / (2 * den);
    if (n < 0) q = -q;
    return 16'(clamp(q, -32768, 32767));
  endfunction

  // extent and texture numerators (over sz) of one axis
  function automatic void axis_span(input longint lo, lsz, sz, c, cs,
                                    output longint ext, t0, t1);
    longint calc, cons, span, toff, tlen;
    calc = lsz < 0 ? lsz - mag(lo) : lsz;
    cons = lo < 0 ? 0 : lo;
    span = (lo + calc > sz) ? sz - cons : calc;
    if (span < 0) span = (span + lo > 0) ? span + lo : 0;
    ext = span;
    t0 = c * sz + (lo < 0 ? cs * mag(lo) : 0);
    toff = (lo + calc > sz || lo < 0) ? cs * mag(lo) : 0;
    tlen = cs * sz - toff;
    if (lsz < sz) tlen -= cs * (sz - lsz);
    t1 = t0 + tlen;
  endfunction

  function automatic quad_t quad_predict(longint rx, ry, rw, rh, cx, cy, cw, ch);
    longint lx, ly, lw, lh, tw, th, px, py, wid, hgt, u0, u1, v0, v1, e0, e2;
    quad_t  res;
    lx = longint'($signed(lim_x));
    ly = longint'($signed(lim_y));
    lw = longint'($signed(lim_w));
    lh = longint'($signed(lim_h));
    tw = tex_w != 0 ? longint'(tex_w) : 1;
    th = tex_h != 0 ? longint'(tex_h) : 1;
    if (rw == 0 || rh == 0 || lx >= rw || ly >= rh) begin
      held_quad = '0;
      res = held_quad;
      res.rd = 1'b1;
      return res;
    end
    px = lx < 0 ? rx : rx + lx;
    py = ly < 0 ? ry : ry + ly;
    if (px[15:0] == pos_x && py[15:0] == pos_y && !lim_dirty) begin
      res = held_quad;
      res.rd = 1'b0;
      return res;
    end
    axis_span(lx, lw, rw, cx, cw, wid, u0, u1);
    axis_span(ly, lh, rh, cy, ch, hgt, v0, v1);
    lim_dirty = 0;
    pos_x = px[15:0];
    pos_y = py[15:0];
    e0 = 2 * px - longint'(scr_w);
    e2 = longint'(scr_h) - 2 * py;
    held_quad.el = 18'(clamp(e0, -131072, 131071));
    held_quad.er = 18'(clamp(e0 + 2 * wid, -131072, 131071));
    held_quad.et = 18'(clamp(e2, -131072, 131071));
    held_quad.eb = 18'(clamp(e2 - 2 * hgt, -131072, 131071));
    held_quad.ul = to_q14(u0, rw * tw);
    held_quad.ur = to_q14(u1, rw * tw);
    held_quad.vt = to_q14(v0, rh * th);
    held_quad.vb = to_q14(v1, rh * th);
    res = held_quad;
    res.rd = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    quad_t got, want;
    if (rst) begin
      lim_x = '0; lim_y = '0; lim_w = '0; lim_h = '0;
      scr_w = 15'd640; scr_h = 15'd480; tex_w = 15'd256; tex_h = 15'd256;
      pos_x = '1; pos_y = '1;
      lim_dirty = 0;
      held_quad = '0;
      quad_expected.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{edge_left, edge_right, edge_top, edge_bottom,
                u_left, u_right, v_top, v_bottom, redrawn};
        if (quad_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result %p", $realtime, got);
        end else begin
          want = quad_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: quad mismatch\n  expected %p\n  actual   %p",
                       $realtime, want, got);
          end
        end
      end
      if (in_valid && !in_stall)
        quad_expected.push_back(quad_predict(longint'(rect_x), longint'(rect_y),
            longint'(rect_w), longint'(rect_h), longint'(clip_x), longint'(clip_y),
            longint'(clip_w), longint'(clip_h)));
      if (cfg_we && !cfg_index[3]) begin
        case (reg_idx_t'(cfg_index[2:0]))
          REG_LIMIT_X: begin lim_dirty |= cfg_data != lim_x; lim_x = cfg_data; end
          REG_LIMIT_Y: begin lim_dirty |= cfg_data != lim_y; lim_y = cfg_data; end
          REG_LIMIT_W: begin lim_dirty |= cfg_data != lim_w; lim_w = cfg_data; end
          REG_LIMIT_H: begin lim_dirty |= cfg_data != lim_h; lim_h = cfg_data; end
          REG_SCREEN_W: scr_w = cfg_data[14:0];
          REG_SCREEN_H: scr_h = cfg_data[14:0];
          REG_TEX_W:    tex_w = cfg_data[14:0];
          REG_TEX_H:    tex_h = cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/textured_quad_clip_setup_top_tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the quad clip setup block
`timescale 1ns / 100ps
`default_nettype none
module textured_quad_clip_setup_top_tb;
  import tqcs_pkg::*;

  localparam int         IdleLimit   = 6000;  // cycles without any transaction
  localparam int         ItemsPerSet = 193;
  localparam logic [3:0] CfgSpare    = 4'd8;  // first index beyond the register file

  logic               clk, rst;
  logic               in_valid, in_stall;
  logic signed [15:0] rect_x, rect_y;
  logic [14:0]        rect_w, rect_h, clip_x, clip_y, clip_w, clip_h;
  logic               out_valid, out_stall;
  logic signed [17:0] edge_left, edge_right, edge_top, edge_bottom;
  logic signed [15:0] u_left, u_right, v_top, v_bottom;
  logic               redrawn;
  logic               cfg_we;
  logic [3:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 mismatches, awaiting;
  int                 burst_left, idle_cycles, stall_pct, stall_phase;

  textured_quad_clip_setup_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
    .clip_x(clip_x), .clip_y(clip_y), .clip_w(clip_w), .clip_h(clip_h),
    .out_valid(out_valid), .out_stall(out_stall),
    .edge_left(edge_left), .edge_right(edge_right), .edge_top(edge_top),
    .edge_bottom(edge_bottom), .u_left(u_left), .u_right(u_right),
    .v_top(v_top), .v_bottom(v_bottom), .redrawn(redrawn),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  quad_clip_checker chk (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver: stall density changes from phase to phase, including
  // stretches with no stall at all.
  always @(posedge clk) begin
    if (rst) begin
      stall_phase <= 0;
      stall_pct   <= 0;
      out_stall   <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 400 == 0)
        stall_pct <= $urandom_range(0, 3) * 25;
      out_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Present one transaction and hold it until accepted; after the burst runs
  // out, drop valid for a random gap.
  task automatic send_quad(logic signed [15:0] x, y, logic [14:0] w, h, cx, cy, cw, ch);
    in_valid <= 1'b1;
    rect_x <= x; rect_y <= y; rect_w <= w; rect_h <= h;
    clip_x <= cx; clip_y <= cy; clip_w <= cw; clip_h <= ch;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Drop valid and wait until every outstanding quad has come back.
  task automatic drain;
    @(posedge clk);
    in_valid <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Hold we high across a run of writes; the caller lowers it afterwards.
  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= {1'b0, idx};
    cfg_data  <= value;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_limit(int flavour);
    case (flavour)
      0: return 16'd0;
      1: return 16'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_size(int flavour);
    case (flavour)
      0: return 16'($urandom_range(1, 1024));
      1: return 16'h7FFF;
      2: return 16'd0;
      default: return 16'($urandom_range(0, 32767));
    endcase
  endfunction

  initial begin
    logic signed [15:0] x, y;
    logic [14:0]        w, h, cx, cy, cw, ch;
    int                 flavour;

    rst = 1'b1;
    in_valid = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    rect_x = '0; rect_y = '0; rect_w = '0; rect_h = '0;
    clip_x = '0; clip_y = '0; clip_w = '0; clip_h = '0;
    burst_left = 4;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: position -1,-1 matches the stored one, so the zero quad is
    // held without a redraw.
    send_quad(-16'sd1, -16'sd1, 15'd10, 15'd10, 15'd1, 15'd2, 15'd3, 15'd4);
    send_quad(16'sd0, 16'sd0, 15'd1, 15'd1, 15'd0, 15'd0, 15'd0, 15'd0);
    send_quad(16'sd0, 16'sd0, 15'd1, 15'd1, 15'd0, 15'd0, 15'd0, 15'd0);
    send_quad(16'sh7FFF, 16'sh8000, 15'h7FFF, 15'h7FFF,
              15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_quad(16'sh8000, 16'sh7FFF, 15'd1, 15'h7FFF, 15'h7FFF, 15'd0, 15'h7FFF, 15'd0);
    // empty sprite in either direction
    send_quad(16'sd5, 16'sd5, 15'd0, 15'd9, 15'd1, 15'd1, 15'd8, 15'd8);
    send_quad(16'sd5, 16'sd5, 15'd9, 15'd0, 15'd1, 15'd1, 15'd8, 15'd8);
    drain();

    write_reg(REG_LIMIT_X, 16'd3);
    write_reg(REG_LIMIT_Y, -16'sd2);
    write_reg(REG_LIMIT_W, -16'sd5);
    write_reg(REG_LIMIT_H, 16'd8);
    cfg_we <= 1'b0;
    // origin right of a narrow sprite
    send_quad(16'sd10, 16'sd20, 15'd3, 15'd40, 15'd4, 15'd5, 15'd30, 15'd20);
    send_quad(16'sd10, 16'sd20, 15'd50, 15'd40, 15'd4, 15'd5, 15'd30, 15'd20);
    send_quad(16'sd10, 16'sd20, 15'd50, 15'd40, 15'd4, 15'd5, 15'd30, 15'd20);
    drain();

    // same value again: no change of limits, so the quad is still held
    write_reg(REG_LIMIT_X, 16'd3);
    cfg_we <= 1'b0;
    send_quad(16'sd10, 16'sd20, 15'd50, 15'd40, 15'd4, 15'd5, 15'd30, 15'd20);
    drain();

    // origin below the sprite
    write_reg(REG_LIMIT_Y, 16'd45);
    cfg_we <= 1'b0;
    send_quad(16'sd10, 16'sd20, 15'd50, 15'd40, 15'd4, 15'd5, 15'd30, 15'd20);
    drain();

    // zero texture size counts as one; extreme constraint sizes
    write_reg(REG_LIMIT_Y, -16'sd2);
    write_reg(REG_TEX_W, 16'd0);
    write_reg(REG_TEX_H, 16'd0);
    cfg_we <= 1'b0;
    send_quad(16'sd7, -16'sd7, 15'd20, 15'd30, 15'd2, 15'd3, 15'd9, 15'd11);
    drain();
    write_reg(REG_LIMIT_W, 16'h7FFF);
    write_reg(REG_LIMIT_H, 16'h8000);
    cfg_we <= 1'b0;
    send_quad(16'sd7, -16'sd7, 15'd20, 15'd30, 15'd2, 15'd3, 15'd9, 15'd11);
    send_quad(16'sd8, -16'sd7, 15'd20, 15'd30, 15'd2, 15'd3, 15'd9, 15'd11);
    drain();

    // Random phases: a fresh setting of every register, then mostly sprites of
    // modest size with repeats so that held quads come back often.
    for (int set = 0; set < 7; set++) begin
      flavour = set == 0 ? 1 : set % 4;
      write_reg(REG_LIMIT_X, pick_limit(flavour));
      write_reg(REG_LIMIT_Y, pick_limit(flavour));
      write_reg(REG_LIMIT_W, pick_limit(set % 2 ? 1 : flavour));
      write_reg(REG_LIMIT_H, pick_limit(set % 2 ? 3 : flavour));
      write_reg(REG_SCREEN_W, pick_size(set % 4));
      write_reg(REG_SCREEN_H, pick_size((set + 1) % 4));
      write_reg(REG_TEX_W, pick_size((set + 2) % 4));
      write_reg(REG_TEX_H, pick_size((set + 3) % 4));
      // writes beyond the register file must change nothing
      cfg_we    <= 1'b1;
      cfg_index <= CfgSpare | 4'($urandom_range(0, 7));
      cfg_data  <= 16'($urandom);
      @(posedge clk);
      cfg_we <= 1'b0;

      x = '0; y = '0; w = 15'd1; h = 15'd1; cx = '0; cy = '0; cw = '0; ch = '0;
      for (int n = 0; n < ItemsPerSet; n++) begin
        if ($urandom_range(0, 99) >= 20 || n == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            x = 16'($urandom); y = 16'($urandom);
          end else begin
            x = 16'($signed($urandom_range(0, 800)) - 100);
            y = 16'($signed($urandom_range(0, 600)) - 100);
          end
          case ($urandom_range(0, 9))
            0: begin w = 15'($urandom); h = 15'($urandom); end
            1: begin w = 15'($urandom_range(0, 1)); h = 15'($urandom_range(0, 1)); end
            default: begin
              w = 15'($urandom_range(1, 200)); h = 15'($urandom_range(1, 200));
            end
          endcase
          cx = 15'($urandom); cy = 15'($urandom);
          cw = 15'($urandom); ch = 15'($urandom);
          if ($urandom_range(0, 1)) begin
            cx = cx & 15'h01FF; cy = cy & 15'h01FF;
            cw = cw & 15'h01FF; ch = ch & 15'h01FF;
          end
        end
        send_quad(x, y, w, h, cx, cy, cw, ch);
        // let the block run completely dry now and then
        if (n == ItemsPerSet / 2) drain();
      end
      drain();
    end

    repeat (250) @(posedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
